// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the generator checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, inactive while reset is asserted
`define MTP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication from a cycle condition to a condition in the next cycle
`define MTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mtp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtp_pkg
// constants, types and word functions of the mt19937 generator
// ----------------------------------------------------------------------------
package mtp_pkg;

	localparam int unsigned TABLE_WORDS_DEF = 624;
	localparam int unsigned TWIST_OFFSET    = 397;

	localparam logic [31:0] SEED_MULT    = 32'd69069;
	localparam logic [31:0] DEFAULT_SEED = 32'd4357;
	localparam logic [31:0] MATRIX_A     = 32'h9908_b0df;
	localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
	localparam logic [31:0] LOWER_MASK   = 32'h7fff_ffff;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

	localparam logic CMD_SEED = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_TW_INIT,
		ST_TW_LOAD,
		ST_TW_READ,
		ST_TW_WRITE,
		ST_DRAW_READ,
		ST_DRAW_OUT
	} state_t;

	function automatic logic [31:0] twist_word(input logic [31:0] cur, input logic [31:0] nxt,
			input logic [31:0] far);
		logic [31:0] y;
		logic [31:0] v;
		y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ MATRIX_A;
		end
		return v;
	endfunction

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// ===== src/mersenne_twister_prng_core.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_prng_core
// mt19937 generator with multiplicative seeding, one table word per step
// ----------------------------------------------------------------------------
//  channel  dir  payload                               handshake
//  s_*      in   tuser = cmd, tdata = seed_value       s_tvalid / s_tready
//  m_*      out  tdata = random_word                   m_tvalid / m_tready
//
//  seed: accept, then one table word written per cycle in the fill
//  draw with words left: accept, table read, temper
//  draw on an exhausted table adds the twist (init, load, then
//  one word per read/write pair on the table memory); unseeded adds the fill
//  arst_n clears the sequencer and marks the table as never seeded
//  a draw holds in its last step while the output register is full
// ----------------------------------------------------------------------------
module mersenne_twister_prng_core
	import mtp_pkg::*;
#(
	parameter int unsigned TABLE_WORDS = TABLE_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,  // [0] cmd
	input  logic [31:0] s_tdata,  // [31:0] seed_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [31:0] random_word
);

	localparam int unsigned ADDR_W = $clog2(TABLE_WORDS);
	localparam int unsigned IDX_W  = $clog2(TABLE_WORDS + 2);
	localparam logic [IDX_W-1:0]  IDX_EXHAUSTED = IDX_W'(TABLE_WORDS);
	localparam logic [IDX_W-1:0]  IDX_NEVER     = IDX_W'(TABLE_WORDS + 1);
	localparam logic [ADDR_W-1:0] ADDR_LAST     = ADDR_W'(TABLE_WORDS - 1);
	localparam logic [ADDR_W-1:0] FAR_OFS       = ADDR_W'(TWIST_OFFSET);
	localparam logic [ADDR_W-1:0] FAR_WRAP      = ADDR_W'(TABLE_WORDS - TWIST_OFFSET);

	state_t            state_q;
	state_t            state_d;
	logic [ADDR_W-1:0] k_q;
	logic [IDX_W-1:0]  ridx_q;
	logic              pend_q;
	logic [31:0]       fill_q;
	logic [31:0]       cur_q;
	logic              m_valid_q;
	logic [31:0]       m_data_q;

	logic              s_acc;
	logic              out_free;
	logic              draw_load;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [31:0]       wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic [31:0]       rd_data_a;
	logic [31:0]       rd_data_b;
	logic [ADDR_W-1:0] k_next;
	logic [ADDR_W-1:0] k_far;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign k_next = (k_q == ADDR_LAST) ? '0 : k_q + ADDR_W'(1);
	assign k_far  = (k_q >= FAR_WRAP) ? k_q - FAR_WRAP : k_q + FAR_OFS;

	mtp_table #(
		.DEPTH  (TABLE_WORDS),
		.ADDR_W (ADDR_W),
		.DATA_W (32)
	) u_table (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		wr_en     = 1'b0;
		wr_addr   = k_q;
		wr_data   = fill_q;
		rd_en     = 1'b0;
		rd_addr_a = k_next;
		rd_addr_b = k_far;
		draw_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (s_tuser == CMD_SEED || ridx_q == IDX_NEVER) begin
						state_d = ST_FILL;
					end else if (ridx_q >= IDX_EXHAUSTED) begin
						state_d = ST_TW_INIT;
					end else begin
						state_d = ST_DRAW_READ;
					end
				end
			end
			ST_FILL: begin
				wr_en = 1'b1;
				if (k_q == ADDR_LAST) begin
					state_d = pend_q ? ST_TW_INIT : ST_IDLE;
				end
			end
			ST_TW_INIT: begin
				rd_en     = 1'b1;
				rd_addr_a = '0;
				state_d   = ST_TW_LOAD;
			end
			ST_TW_LOAD: begin
				state_d = ST_TW_READ;
			end
			ST_TW_READ: begin
				rd_en   = 1'b1;
				state_d = ST_TW_WRITE;
			end
			ST_TW_WRITE: begin
				wr_en   = 1'b1;
				wr_data = twist_word(cur_q, rd_data_a, rd_data_b);
				state_d = (k_q == ADDR_LAST) ? ST_DRAW_READ : ST_TW_READ;
			end
			ST_DRAW_READ: begin
				rd_en     = 1'b1;
				rd_addr_a = ridx_q[ADDR_W-1:0];
				state_d   = ST_DRAW_OUT;
			end
			ST_DRAW_OUT: begin
				if (out_free) begin
					draw_load = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer counters and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			ridx_q <= IDX_NEVER;
			pend_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						k_q    <= '0;
						pend_q <= (s_tuser == CMD_DRAW);
					end
				end
				ST_FILL: begin
					k_q <= k_next;
					if (k_q == ADDR_LAST) begin
						ridx_q <= IDX_EXHAUSTED;
					end
				end
				ST_TW_WRITE: begin
					k_q <= k_next;
					if (k_q == ADDR_LAST) begin
						ridx_q <= '0;
					end
				end
				ST_DRAW_OUT: begin
					if (draw_load) begin
						ridx_q <= ridx_q + IDX_W'(1);
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// seed chain and carried table word
	always_ff @(posedge clk) begin
		if (s_acc) begin
			fill_q <= (s_tuser == CMD_SEED) ? s_tdata : DEFAULT_SEED;
		end else if (state_q == ST_FILL) begin
			fill_q <= 32'(fill_q * SEED_MULT);
		end
		if (state_q == ST_TW_LOAD || state_q == ST_TW_WRITE) begin
			cur_q <= rd_data_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (draw_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_load) begin
			m_data_q <= temper(rd_data_a);
		end
	end

endmodule

// ===== src/mtp_table.sv =====
// ----------------------------------------------------------------------------
// mtp_table
// state table memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mtp_table #(
	parameter int unsigned DEPTH  = 624,
	parameter int unsigned ADDR_W = 10,
	parameter int unsigned DATA_W = 32
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [DATA_W-1:0] rd_data_a,
	output logic [DATA_W-1:0] rd_data_b
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ===== src/mtp_checker.sv =====
// ----------------------------------------------------------------------------
// mtp_checker
// port-level checks of the generator, attached to the top level by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtp_checker
	import mtp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	logic s_acc;
	logic seed_acc;

	assign s_acc    = s_tvalid && s_tready;
	assign seed_acc = s_acc && (s_tuser == CMD_SEED);

	`MTP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`MTP_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
	`MTP_ASSERT_NEXT(a_busy_after_acc, clk, arst_n, s_acc, !s_tready, "ready right after a transaction")
	`MTP_ASSERT_NEXT(a_seed_no_result, clk, arst_n, seed_acc, !$rose(m_tvalid), "seed produced a result")

endmodule

bind mersenne_twister_prng_core mtp_checker u_mtp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the mt19937 generator core: seed and draw
// transactions go in on the slave stream, and every drawn word is compared
// with an in-bench model of the seeding, the twist and the tempering
// ----------------------------------------------------------------------------
module tb;

	import mtp_pkg::CMD_SEED;
	import mtp_pkg::CMD_DRAW;

	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned DRAIN_CYCLES = 2000;

	class mt_word_checker;
		localparam int unsigned N_WORDS = 624;
		localparam int unsigned FAR_STEP = 397;
		localparam logic [9:0] UNSEEDED = 10'd625;
		localparam logic [31:0] MULT_K = 32'd69069;
		localparam logic [31:0] FALLBACK_SEED = 32'd4357;
		localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
		localparam logic [31:0] HI_BIT = 32'h8000_0000;
		localparam logic [31:0] LO_BITS = 32'h7fff_ffff;
		localparam logic [31:0] SHAPE_B = 32'h9d2c_5680;
		localparam logic [31:0] SHAPE_C = 32'hefc6_0000;

		logic [31:0] mt_words [N_WORDS];
		logic [9:0] next_pos;
		logic [31:0] words_due [$];
		int mismatches;
		int seeds_seen;
		int draws_seen;
		int words_checked;
		int regenerations;

		function new();
			foreach (mt_words[i]) mt_words[i] = '0;
			next_pos = UNSEEDED;
			mismatches = 0;
			seeds_seen = 0;
			draws_seen = 0;
			words_checked = 0;
			regenerations = 0;
		endfunction

		function void reseed(logic [31:0] s);
			mt_words[0] = s;
			for (int i = 1; i < N_WORDS; i++) mt_words[i] = MULT_K * mt_words[i - 1];
			next_pos = N_WORDS;
		endfunction

		function void regenerate();
			logic [31:0] y;
			logic [31:0] v;
			for (int k = 0; k < N_WORDS; k++) begin
				y = (mt_words[k] & HI_BIT) | (mt_words[(k + 1) % N_WORDS] & LO_BITS);
				v = mt_words[(k + FAR_STEP) % N_WORDS] ^ (y >> 1);
				if (y[0]) begin
					v = v ^ TWIST_XOR;
				end
				mt_words[k] = v;
			end
			next_pos = '0;
			regenerations++;
		endfunction

		function logic [31:0] shaped(logic [31:0] w);
			logic [31:0] y;
			y = w ^ (w >> 11);
			y = y ^ ((y << 7) & SHAPE_B);
			y = y ^ ((y << 15) & SHAPE_C);
			return y ^ (y >> 18);
		endfunction

		function void note_input(logic cmd, logic [31:0] val);
			if (cmd == CMD_SEED) begin
				seeds_seen++;
				reseed(val);
			end else begin
				draws_seen++;
				if (next_pos >= N_WORDS) begin
					if (next_pos == UNSEEDED) begin
						reseed(FALLBACK_SEED);
					end
					regenerate();
				end
				words_due.push_back(shaped(mt_words[next_pos]));
				next_pos = next_pos + 10'd1;
			end
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			$display("%0t mismatch: %s, random_word got %h expected %h", $realtime, what, got,
				want);
		endtask

		task check_result(logic [31:0] word);
			logic [31:0] want;
			if (words_due.size() == 0) begin
				report("word with no draw pending", word, '0);
			end else begin
				want = words_due.pop_front();
				words_checked++;
				if (word !== want) begin
					report("wrong word", word, want);
				end
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic        s_tuser = 1'b0;  // [0] cmd
	logic [31:0] s_tdata = '0;    // [31:0] seed_value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [31:0] random_word

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	mt_word_checker tracker;

	mersenne_twister_prng_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				tracker.check_result(m_tdata);
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task send_item(input logic cmd, input logic [31:0] val);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= val;
		do @(posedge clk); while (!s_tready);
		tracker.note_input(cmd, val);
	endtask

	function logic [31:0] pick_seed();
		int r;
		r = $urandom_range(99);
		if (r < 8) begin
			return '0;
		end else if (r < 14) begin
			return '1;
		end
		return $urandom;
	endfunction

	// mostly seed-then-draw runs with random lengths, some runs continue the
	// previous stream, some seeds come back to back
	task run_phase(input int budget, input bit with_long_run);
		int sent;
		int n;
		sent = 0;
		while (sent < budget) begin
			if (sent == 0 || $urandom_range(99) < 80) begin
				if ($urandom_range(99) < 15) begin
					send_item(CMD_SEED, pick_seed());
					sent++;
				end
				send_item(CMD_SEED, pick_seed());
				sent++;
			end
			n = (with_long_run && sent < 3) ? 640 : $urandom_range(1, 40);
			repeat (n) begin
				send_item(CMD_DRAW, $urandom);
				sent++;
			end
		end
	endtask

	initial begin
		tracker = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// draws before any seed, zero seed, extremes, default seed again,
		// repeated seeds
		send_item(CMD_DRAW, 32'hffff_ffff);
		send_item(CMD_DRAW, 32'h0000_0000);
		send_item(CMD_DRAW, $urandom);
		send_item(CMD_SEED, 32'h0000_0000);
		repeat (3) send_item(CMD_DRAW, $urandom);
		send_item(CMD_SEED, 32'hffff_ffff);
		repeat (2) send_item(CMD_DRAW, $urandom);
		send_item(CMD_SEED, 32'd4357);
		repeat (2) send_item(CMD_DRAW, $urandom);
		send_item(CMD_SEED, 32'h0000_0001);
		send_item(CMD_SEED, 32'h8000_0000);
		repeat (2) send_item(CMD_DRAW, $urandom);
		send_item(CMD_SEED, 32'h7fff_ffff);
		send_item(CMD_DRAW, $urandom);

		run_phase(700, 1'b1);
		send_idle_pct = 86;
		run_phase(230, 1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 86;
		run_phase(230, 1'b0);
		send_idle_pct = 15;
		recv_stall_pct = 15;
		run_phase(230, 1'b0);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.words_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d seed and %0d draw transactions, %0d words compared,",
			tracker.seeds_seen, tracker.draws_seen, tracker.words_checked);
		$display("%0d table twists, with and without idling on either stream",
			tracker.regenerations);
		if (tracker.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/mtp_pkg.sv
src/mtp_table.sv
src/mersenne_twister_prng_core.sv
src/mtp_checker.sv
tb/tb.sv
